[rtl/bbp_pkg.sv]
// shared types and constants of the bicubic bezier patch point unit
package bbp_pkg;

   localparam int SLOT_W      = 4;
   localparam int SEG_W       = 7;
   localparam int STEP_W      = 7;
   localparam int NUM_W       = 23;
   localparam int T_W         = 17;
   localparam int SQ_W        = 2 * T_W;
   localparam int RAW_W       = 51;
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_W     = 25;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int AXES        = 2;
   localparam int AXIS_U      = 0;
   localparam int AXIS_V      = 1;

   localparam logic [SEG_W-1:0] SEGMENTS_RESET = 7'd20;
   localparam logic [T_W-1:0]   ONE_Q16        = 17'h10000;

   // item mode codes
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_EVAL = 1'b1;

   // classified item as it travels from front to back
   typedef struct packed {
      logic                is_eval;
      logic [SLOT_W-1:0]   slot;
      logic [NUM_W-1:0]    num_u;
      logic [NUM_W-1:0]    num_v;
      logic [SEG_W-1:0]    seg;
      logic                clamped;
   } bbp_item_type;

   localparam int ITEM_W = $bits(bbp_item_type);

endpackage

[rtl/bicubic_bezier_patch_point_unit.sv]
// bicubic bezier patch point unit: top level with stream ports and segments register
// an evaluate transfer goes through the front register, the queue and the evaluation pipeline to its result
// throughput: one item per cycle unless the output stalls; front stage, a four-entry queue and a nine-stage
// evaluation pipeline that advances whenever the output register is free or taken
// load items update the control points in order and give no result
// reset: synchronous; clears valids and queue, segments returns to 20, points stay unset
module bicubic_bezier_patch_point_unit #(
   parameter int MAX_SEGMENTS = 64,
   parameter int COORD_WIDTH  = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // point_index, coord_x, coord_y, coord_z, u_step, v_step, zero fill
   input  logic [((18 + 3*COORD_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   // mode
   input  logic                                       req_tuser,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // point_x, point_y, point_z, zero fill
   output logic [((3*COORD_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,
   // step_clamped
   output logic                                       rsp_tuser,
   input  logic                                       csr_wr_en,
   input  logic [bbp_pkg::SEG_W-1:0]                  csr_wr_data
);
   import bbp_pkg::*;

   localparam int CW     = COORD_WIDTH;
   localparam int OUT_DW = ((3*CW + 7) / 8) * 8;
   localparam int QW     = ITEM_W + 3*CW;

   logic [SEG_W-1:0]  segments_ff;
   logic              f_valid, f_ready, q_valid, q_ready;
   bbp_item_type      f_item, b_item;
   logic [3*CW-1:0]   f_coords, b_coords, point;
   logic [QW-1:0]     q_data;
   logic              clamped;

   // segments register
   always_ff @(posedge clock) begin
      if (reset) begin
         segments_ff <= SEGMENTS_RESET;
      end else if (csr_wr_en) begin
         segments_ff <= csr_wr_data;
      end
   end

   bbp_front #(.MAX_SEGMENTS(MAX_SEGMENTS), .CW(CW)) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_mode    (req_tuser),
      .in_slot    (req_tdata[SLOT_W-1:0]),
      .in_coords  (req_tdata[SLOT_W +: 3*CW]),
      .in_u_step  (req_tdata[SLOT_W + 3*CW +: STEP_W]),
      .in_v_step  (req_tdata[SLOT_W + 3*CW + STEP_W +: STEP_W]),
      .segments   (segments_ff),
      .out_valid  (f_valid),
      .out_ready  (f_ready),
      .out_item   (f_item),
      .out_coords (f_coords)
   );

   bbp_queue #(.WIDTH(QW)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  ({f_coords, f_item}),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   assign b_item   = q_data[ITEM_W-1:0];
   assign b_coords = q_data[ITEM_W +: 3*CW];

   bbp_back #(.CW(CW)) u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (q_valid),
      .in_ready    (q_ready),
      .in_item     (b_item),
      .in_coords   (b_coords),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_point   (point),
      .out_clamped (clamped)
   );

   assign rsp_tdata = OUT_DW'(point);
   assign rsp_tuser = clamped;

endmodule

[rtl/bbp_front.sv]
// front end: accepts items, clamps the grid steps and forms the parameter numerators
module bbp_front #(
   parameter int MAX_SEGMENTS = 64,
   parameter int CW           = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic                       in_mode,
   input  logic [bbp_pkg::SLOT_W-1:0] in_slot,
   input  logic [3*CW-1:0]            in_coords,
   input  logic [bbp_pkg::STEP_W-1:0] in_u_step,
   input  logic [bbp_pkg::STEP_W-1:0] in_v_step,
   input  logic [bbp_pkg::SEG_W-1:0]  segments,
   output logic                       out_valid,
   input  logic                       out_ready,
   output bbp_pkg::bbp_item_type      out_item,
   output logic [3*CW-1:0]            out_coords
);
   import bbp_pkg::*;

   logic                 valid_ff, valid_in;
   bbp_item_type         item_ff, item_in;
   logic [3*CW-1:0]      coords_ff;
   logic [SEG_W-1:0]     seg_eff;
   logic [STEP_W-1:0]    u_sat, v_sat;
   logic                 take;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   // effective segment count
   always_comb begin
      if (segments == '0) begin
         seg_eff = SEG_W'(1);
      end else if (int'(segments) > MAX_SEGMENTS) begin
         seg_eff = SEG_W'(MAX_SEGMENTS);
      end else begin
         seg_eff = segments;
      end
   end

   // step saturation and numerator i*2^16 + seg/2
   always_comb begin
      u_sat = (in_u_step > seg_eff) ? seg_eff : in_u_step;
      v_sat = (in_v_step > seg_eff) ? seg_eff : in_v_step;
      item_in.is_eval = (in_mode == MODE_EVAL);
      item_in.slot    = in_slot;
      item_in.seg     = seg_eff;
      item_in.clamped = (in_u_step > seg_eff) || (in_v_step > seg_eff);
      item_in.num_u   = NUM_W'({u_sat, 16'b0}) + NUM_W'(seg_eff >> 1);
      item_in.num_v   = NUM_W'({v_sat, 16'b0}) + NUM_W'(seg_eff >> 1);
      valid_in = take || (valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         item_ff   <= item_in;
         coords_ff <= in_coords;
      end
   end

   assign out_valid  = valid_ff;
   assign out_item   = item_ff;
   assign out_coords = coords_ff;

endmodule

[rtl/bbp_queue.sv]
// short fifo between the front end and the evaluation pipeline
module bbp_queue #(
   parameter int WIDTH = 107
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   import bbp_pkg::*;

   logic [WIDTH-1:0]  entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              push, pop;

   assign push_ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_W+1)'(QUEUE_DEPTH))
      else $error("queue fill count out of range");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      !push_ready && !pop_ready |=> !push_ready)
      else $error("full queue drained without a pop");

endmodule

[rtl/bbp_back.sv]
// evaluation pipeline: parameter division, bernstein weights, control points, u then v blend
module bbp_back #(
   parameter int CW = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  bbp_pkg::bbp_item_type in_item,
   input  logic [3*CW-1:0]       in_coords,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [3*CW-1:0]       out_point,
   output logic                  out_clamped
);
   import bbp_pkg::*;

   localparam int AW  = CW + 4;
   localparam int PUW = CW + 18;
   localparam int SUW = CW + 20;
   localparam int PVW = AW + 18;
   localparam int SVW = AW + 20;
   localparam int RW  = SVW - 16;
   localparam logic signed [RW-1:0] SAT_HI = RW'((64'sd1 <<< (CW - 1)) - 64'sd1);
   localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

   logic                   en;
   logic [9:1]             vld_ff, vld_in;
   logic [RECIP_W-1:0]     recip [128];

   bbp_item_type           it1_ff, it2_ff, it3_ff, it4_ff, it5_ff;
   logic [3*CW-1:0]        co1_ff, co2_ff, co3_ff, co4_ff, co5_ff;
   logic [T_W-1:0]         q1_ff [AXES], q1_in [AXES];
   logic [T_W-1:0]         t2_ff [AXES], t2_in [AXES];
   logic [T_W-1:0]         t3_ff [AXES], s3_ff [AXES], s_in [AXES];
   logic [SQ_W-1:0]        tt3_ff [AXES], ts3_ff [AXES], ss3_ff [AXES];
   logic [RAW_W-1:0]       raw4_ff [AXES][4], raw4_in [AXES][4];
   logic [T_W-1:0]         w5_ff [AXES][4], w5_in [AXES][4];
   logic signed [CW-1:0]   pts_ff [16][3];
   logic signed [PUW-1:0]  pu6_ff [4][4][3], pu6_in [4][4][3];
   logic [T_W-1:0]         wv6_ff [4], wv7_ff [4];
   logic signed [AW-1:0]   a7_ff [4][3], a7_in [4][3];
   logic signed [PVW-1:0]  pv8_ff [4][3], pv8_in [4][3];
   logic signed [CW-1:0]   p9_ff [3], p9_in [3];
   logic [8:6]             ev_ff, cl_ff;
   logic                   ev9_ff, cl9_ff;

   // reciprocal table ceil(2^24 / seg)
   assign recip[0] = '0;
   for (genvar Sv = 1; Sv < 128; Sv++) begin : g_recip
      assign recip[Sv] = RECIP_W'(((1 << RECIP_SHIFT) + Sv - 1) / Sv);
   end

   // the whole pipeline advances unless a result waits at the output
   assign en        = !out_valid || out_ready;
   assign in_ready  = en;
   assign vld_in    = {vld_ff[8:1], in_valid};
   assign out_valid = vld_ff[9] && ev9_ff;

   // stage 1: quotient estimate by reciprocal multiply
   always_comb begin
      logic [NUM_W+RECIP_W-1:0] prod_u, prod_v;
      prod_u = (NUM_W+RECIP_W)'(in_item.num_u) * (NUM_W+RECIP_W)'(recip[in_item.seg]);
      prod_v = (NUM_W+RECIP_W)'(in_item.num_v) * (NUM_W+RECIP_W)'(recip[in_item.seg]);
      q1_in[AXIS_U] = prod_u[RECIP_SHIFT +: T_W];
      q1_in[AXIS_V] = prod_v[RECIP_SHIFT +: T_W];
   end

   // stage 2: one-step correction of the estimate
   always_comb begin
      logic [NUM_W:0] back_u, back_v;
      back_u = (NUM_W+1)'(q1_ff[AXIS_U]) * (NUM_W+1)'(it1_ff.seg);
      back_v = (NUM_W+1)'(q1_ff[AXIS_V]) * (NUM_W+1)'(it1_ff.seg);
      t2_in[AXIS_U] = (back_u > (NUM_W+1)'(it1_ff.num_u)) ? q1_ff[AXIS_U] - 1'b1 : q1_ff[AXIS_U];
      t2_in[AXIS_V] = (back_v > (NUM_W+1)'(it1_ff.num_v)) ? q1_ff[AXIS_V] - 1'b1 : q1_ff[AXIS_V];
   end

   // stage 3 and 4: bernstein products, stage 5: round to q16 weights
   always_comb begin
      logic [RAW_W-1:0] m1, m2;
      logic [RAW_W-1:0] biased;
      for (int a = 0; a < AXES; a++) begin
         s_in[a] = ONE_Q16 - t2_ff[a];
         raw4_in[a][0] = RAW_W'(ss3_ff[a]) * RAW_W'(s3_ff[a]);
         m1 = RAW_W'(ts3_ff[a]) * RAW_W'(s3_ff[a]);
         raw4_in[a][1] = (m1 << 1) + m1;
         m2 = RAW_W'(tt3_ff[a]) * RAW_W'(s3_ff[a]);
         raw4_in[a][2] = (m2 << 1) + m2;
         raw4_in[a][3] = RAW_W'(tt3_ff[a]) * RAW_W'(t3_ff[a]);
         for (int j = 0; j < 4; j++) begin
            biased = raw4_ff[a][j] + (RAW_W'(1) << 31);
            w5_in[a][j] = biased[32 +: T_W];
         end
      end
   end

   // stage 6: weight the control points along u
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            for (int p = 0; p < 3; p++) begin
               pu6_in[c][r][p] = $signed({1'b0, w5_ff[AXIS_U][r]}) * pts_ff[4*r + c][p];
            end
         end
      end
   end

   // stage 7: column sums rounded half up
   always_comb begin
      logic signed [SUW-1:0] acc;
      for (int c = 0; c < 4; c++) begin
         for (int p = 0; p < 3; p++) begin
            acc = SUW'(pu6_ff[c][0][p]) + SUW'(pu6_ff[c][1][p])
                + SUW'(pu6_ff[c][2][p]) + SUW'(pu6_ff[c][3][p]) + SUW'(32768);
            a7_in[c][p] = AW'(acc >>> 16);
         end
      end
   end

   // stage 8: weight the columns along v
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int p = 0; p < 3; p++) begin
            pv8_in[c][p] = $signed({1'b0, wv7_ff[c]}) * a7_ff[c][p];
         end
      end
   end

   // stage 9: final sum, rounding and saturation
   always_comb begin
      logic signed [SVW-1:0] acc;
      logic signed [RW-1:0]  rnd;
      for (int p = 0; p < 3; p++) begin
         acc = SVW'(pv8_ff[0][p]) + SVW'(pv8_ff[1][p])
             + SVW'(pv8_ff[2][p]) + SVW'(pv8_ff[3][p]) + SVW'(32768);
         rnd = RW'(acc >>> 16);
         if (rnd > SAT_HI) begin
            p9_in[p] = CW'(SAT_HI);
         end else if (rnd < SAT_LO) begin
            p9_in[p] = CW'(SAT_LO);
         end else begin
            p9_in[p] = CW'(rnd);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
      if (en) begin
         it1_ff <= in_item;   co1_ff <= in_coords;
         it2_ff <= it1_ff;    co2_ff <= co1_ff;
         it3_ff <= it2_ff;    co3_ff <= co2_ff;
         it4_ff <= it3_ff;    co4_ff <= co3_ff;
         it5_ff <= it4_ff;    co5_ff <= co4_ff;
         for (int a = 0; a < AXES; a++) begin
            q1_ff[a]  <= q1_in[a];
            t2_ff[a]  <= t2_in[a];
            t3_ff[a]  <= t2_ff[a];
            s3_ff[a]  <= s_in[a];
            tt3_ff[a] <= SQ_W'(t2_ff[a]) * SQ_W'(t2_ff[a]);
            ts3_ff[a] <= SQ_W'(t2_ff[a]) * SQ_W'(s_in[a]);
            ss3_ff[a] <= SQ_W'(s_in[a]) * SQ_W'(s_in[a]);
            for (int j = 0; j < 4; j++) begin
               raw4_ff[a][j] <= raw4_in[a][j];
               w5_ff[a][j]   <= w5_in[a][j];
            end
         end
         pu6_ff <= pu6_in;
         a7_ff  <= a7_in;
         pv8_ff <= pv8_in;
         p9_ff  <= p9_in;
         for (int c = 0; c < 4; c++) begin
            wv6_ff[c] <= w5_ff[AXIS_V][c];
            wv7_ff[c] <= wv6_ff[c];
         end
         ev_ff  <= {ev_ff[7:6], it5_ff.is_eval};
         cl_ff  <= {cl_ff[7:6], it5_ff.clamped};
         ev9_ff <= ev_ff[8];
         cl9_ff <= cl_ff[8];
         // a load lands where evaluations read the points, keeping item order
         if (vld_ff[5] && !it5_ff.is_eval) begin
            for (int p = 0; p < 3; p++) begin
               pts_ff[it5_ff.slot][p] <= co5_ff[p*CW +: CW];
            end
         end
      end
   end

   for (genvar Gp = 0; Gp < 3; Gp++) begin : g_out
      assign out_point[Gp*CW +: CW] = p9_ff[Gp];
   end
   assign out_clamped = cl9_ff;

   a_param_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[2] && it2_ff.is_eval |-> t2_ff[AXIS_U] <= ONE_Q16 && t2_ff[AXIS_V] <= ONE_Q16)
      else $error("step parameter above one");

   a_quotient_exact: assert property (@(posedge clock) disable iff (reset)
      vld_ff[2] && it2_ff.is_eval |->
         32'(t2_ff[AXIS_U]) * 32'(it2_ff.seg) <= 32'(it2_ff.num_u) &&
         (32'(t2_ff[AXIS_U]) + 32'd1) * 32'(it2_ff.seg) > 32'(it2_ff.num_u))
      else $error("reciprocal division off by one");

   a_weight_sum: assert property (@(posedge clock) disable iff (reset)
      vld_ff[5] && it5_ff.is_eval |->
         19'(w5_ff[AXIS_U][0]) + 19'(w5_ff[AXIS_U][1]) + 19'(w5_ff[AXIS_U][2])
            + 19'(w5_ff[AXIS_U][3]) >= 19'd65533 &&
         19'(w5_ff[AXIS_U][0]) + 19'(w5_ff[AXIS_U][1]) + 19'(w5_ff[AXIS_U][2])
            + 19'(w5_ff[AXIS_U][3]) <= 19'd65539)
      else $error("bernstein weights do not sum to one");

endmodule
